// File: hw/rtl/chip8_instruction_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the instruction core checker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// Asserts that the antecedent implies the consequent in the same cycle.
`define C8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that the antecedent implies the consequent in the next cycle.
`define C8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/c8_pkg.sv
// ----------------------------------------------------------------------------
// Instruction core package
// Shared constants, types and the font table of the instruction core.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int unsigned MemBytes     = 4096;
  localparam int unsigned MemAw        = 12;
  localparam int unsigned StackDepth   = 16;
  localparam int unsigned StackAw      = $clog2(StackDepth);
  localparam int unsigned ScreenWidth  = 64;
  localparam int unsigned ScreenHeight = 32;
  localparam int unsigned RowAw        = 5;
  localparam int unsigned FontBytes    = 80;
  localparam logic [MemAw-1:0] ProgramStart = 12'd512;

  localparam logic [1:0] CmdExec = 2'd0;
  localparam logic [1:0] CmdTick = 2'd1;
  localparam logic [1:0] CmdLoad = 2'd2;
  localparam logic [1:0] CmdRead = 2'd3;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 104;

  typedef struct packed {
    logic [7:0]  data;
    logic [11:0] address;
    logic [15:0] random_value;
    logic [15:0] key_state;
    logic [1:0]  command;
  } in_item_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic        sound_on;
    logic [7:0]  flag_value;
    logic        display_changed;
    logic        waiting_key;
    logic [15:0] opcode;
    logic [11:0] pc;
  } out_item_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic             we;
    logic [MemAw-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  // Framebuffer port request from the sequencer.
  typedef struct packed {
    logic             we;
    logic [RowAw-1:0] addr;
    logic [63:0]      wdata;
  } fb_req_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] f [FontBytes];
    f = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
          8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
          8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    return (idx < 7'(FontBytes)) ? f[idx] : 8'h00;
  endfunction

endpackage

// File: hw/rtl/c8_mem.sv
// ----------------------------------------------------------------------------
// Main memory
// 4096-byte memory with one port and a registered read. A sweep after reset
// writes the font and zeroes the rest, one byte per cycle.
// ----------------------------------------------------------------------------
module c8_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c8_pkg::mem_req_t  req_i,
  output logic [7:0]        rdata_o,
  output logic              init_done_o
);
  import c8_pkg::*;

  logic [7:0]       mem [MemBytes];
  logic [MemAw:0]   sweep_q, sweep_d;
  logic             we;
  logic [MemAw-1:0] addr;
  logic [7:0]       wdata;

  assign init_done_o = sweep_q[MemAw];
  assign sweep_d     = init_done_o ? sweep_q : sweep_q + 1'b1;

  always_comb begin
    if (!init_done_o) begin
      we    = 1'b1;
      addr  = sweep_q[MemAw-1:0];
      wdata = font_byte((sweep_q[MemAw-1:7] == '0) ? sweep_q[6:0] : 7'h7F);
    end else begin
      we    = req_i.we;
      addr  = req_i.addr;
      wdata = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_o <= mem[addr];
  end

endmodule

// File: hw/rtl/c8_fb.sv
// ----------------------------------------------------------------------------
// Framebuffer
// 32 rows of 64 pixels with one port and a registered read. Per-row valid
// bits give rows never written since reset the value zero; clear drops them.
// ----------------------------------------------------------------------------
module c8_fb (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  c8_pkg::fb_req_t  req_i,
  input  logic             clear_i,
  output logic [63:0]      rdata_o,
  output logic             any_set_o
);
  import c8_pkg::*;

  logic [63:0]             rows [ScreenHeight];
  logic [ScreenHeight-1:0] vld_q, vld_d;
  logic [ScreenHeight-1:0] nz_q, nz_d;
  logic [63:0]             rd_q;
  logic                    rd_vld_q;

  always_comb begin
    vld_d = vld_q;
    nz_d  = nz_q;
    if (clear_i) begin
      vld_d = '0;
      nz_d  = '0;
    end else if (req_i.we) begin
      vld_d[req_i.addr] = 1'b1;
      nz_d[req_i.addr]  = (req_i.wdata != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      nz_q     <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      nz_q     <= nz_d;
      rd_vld_q <= vld_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      rows[req_i.addr] <= req_i.wdata;
    end
    rd_q <= rows[req_i.addr];
  end

  assign rdata_o   = rd_vld_q ? rd_q : '0;
  assign any_set_o = (nz_q != '0);

endmodule

// File: hw/rtl/c8_seq.sv
// ----------------------------------------------------------------------------
// Instruction sequencer
// Fetches, decodes and executes one command per beat through the memory
// and framebuffer ports, holding registers, stack and timers.
// ----------------------------------------------------------------------------
module c8_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  c8_pkg::in_item_t   item_i,
  output logic               busy_o,
  output logic               done_o,
  output c8_pkg::out_item_t  res_o,
  output c8_pkg::mem_req_t   mem_o,
  input  logic [7:0]         mem_rdata_i,
  output c8_pkg::fb_req_t    fb_o,
  output logic               fb_clear_o,
  input  logic [63:0]        fb_rdata_i,
  input  logic               fb_any_i
);
  import c8_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_MOD, S_DIV,
    S_BCD, S_BLOCK, S_SPR_MEM, S_SPR_FB, S_SPR_WR, S_RET, S_ROW, S_DONE
  } state_e;

  state_e           state_q;
  in_item_t         it_q;
  logic [7:0]       v_q [16];
  logic [15:0]      i_q;
  logic [MemAw-1:0] pc_q;
  logic [MemAw-1:0] stk_q [StackDepth];
  logic [StackAw:0] sp_q;
  logic [7:0]       dt_q, st_q;
  logic [15:0]      op_q;
  logic [4:0]       cnt_q;
  logic [16:0]      rem_q;
  logic [7:0]       div_q;
  logic [3:0]       tens_q;
  logic [7:0]       bits_q;
  logic             hit_q, chg_q, wait_q, pend_q;
  logic [63:0]      row_q;

  logic [3:0] x, y, n;
  logic [7:0] nn, vx, vy;
  assign x  = op_q[11:8];
  assign y  = op_q[7:4];
  assign n  = op_q[3:0];
  assign nn = op_q[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];

  logic [4:0]  spr_row;
  logic [5:0]  col;
  logic [63:0] mask;
  assign spr_row = 5'(vy + 8'(cnt_q));
  assign col     = vx[5:0];
  // Sprite byte MSB lands on column vx; wrap by folding the upper half.
  logic [63:0] shl;
  assign shl  = 64'({56'd0, bits_q[0], bits_q[1], bits_q[2], bits_q[3],
                     bits_q[4], bits_q[5], bits_q[6], bits_q[7]}) << col;
  assign mask = shl | (64'({56'd0, bits_q[0], bits_q[1], bits_q[2], bits_q[3],
                     bits_q[4], bits_q[5], bits_q[6], bits_q[7]}) >> (7'd64 - {1'b0, col}));

  logic [15:0] lowkey;
  logic [3:0]  keyidx;
  always_comb begin
    keyidx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (it_q.key_state[k]) keyidx = 4'(k);
    end
  end
  assign lowkey = it_q.key_state;

  always_comb begin
    mem_o = '0;
    fb_o  = '0;
    fb_clear_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i && item_i.command == CmdLoad) begin
          mem_o.we    = 1'b1;
          mem_o.addr  = item_i.address;
          mem_o.wdata = item_i.data;
        end else begin
          mem_o.addr = pc_q;
        end
        fb_o.addr = item_i.address[RowAw-1:0];
      end
      S_FETCH_HI: mem_o.addr = pc_q + 12'd1;
      S_BCD: begin
        mem_o.we    = 1'b1;
        mem_o.addr  = i_q[11:0] + 12'(cnt_q);
        mem_o.wdata = (cnt_q == 5'd0) ? div_q : ((cnt_q == 5'd1) ?
                      {4'd0, tens_q} : rem_q[7:0]);
      end
      S_BLOCK: begin
        mem_o.we    = (nn == 8'h55) && (cnt_q <= {1'b0, x});
        mem_o.addr  = i_q[11:0] + 12'(cnt_q);
        mem_o.wdata = v_q[cnt_q[3:0]];
      end
      S_SPR_MEM: mem_o.addr = i_q[11:0] + 12'(cnt_q);
      S_SPR_FB:  fb_o.addr  = spr_row;
      S_SPR_WR: begin
        fb_o.we    = 1'b1;
        fb_o.addr  = spr_row;
        fb_o.wdata = fb_rdata_i ^ mask;
      end
      S_DECODE: fb_clear_o = (op_q == 16'h00E0);
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
      i_q    <= '0;
      pc_q   <= ProgramStart;
      sp_q   <= '0;
      dt_q   <= '0;
      st_q   <= '0;
      op_q   <= '0;
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      chg_q  <= 1'b0;
      wait_q <= 1'b0;
      pend_q <= 1'b0;
      res_o  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            it_q   <= item_i;
            op_q   <= '0;
            chg_q  <= 1'b0;
            wait_q <= 1'b0;
            row_q  <= '0;
            case (item_i.command)
              CmdExec: state_q <= S_FETCH_HI;
              CmdTick: begin
                if (dt_q != 0) dt_q <= dt_q - 8'd1;
                if (st_q != 0) st_q <= st_q - 8'd1;
                state_q <= S_DONE;
              end
              CmdRead: state_q <= S_ROW;
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_ROW: begin
          row_q   <= fb_rdata_i;
          state_q <= S_DONE;
        end
        S_FETCH_HI: begin
          op_q[15:8] <= mem_rdata_i;
          state_q    <= S_FETCH_LO;
        end
        S_FETCH_LO: begin
          op_q[7:0] <= mem_rdata_i;
          state_q   <= S_DECODE;
        end
        S_DECODE: begin
          pc_q    <= pc_q + 12'd2;
          state_q <= S_DONE;
          cnt_q   <= '0;
          case (op_q[15:12])
            4'h0: begin
              if (op_q == 16'h00E0) chg_q <= fb_any_i;
              else if (op_q == 16'h00EE && sp_q != 0) begin
                sp_q  <= sp_q - 1'b1;
                pc_q  <= stk_q[StackAw'(sp_q - 1'b1)] + 12'd2;
              end
            end
            4'h1: pc_q <= op_q[11:0];
            4'h2: begin
              if (sp_q < (StackAw+1)'(StackDepth)) begin
                stk_q[sp_q[StackAw-1:0]] <= pc_q;
                sp_q <= sp_q + 1'b1;
              end
              pc_q <= op_q[11:0];
            end
            4'h3: if (vx == nn) pc_q <= pc_q + 12'd4;
            4'h4: if (vx != nn) pc_q <= pc_q + 12'd4;
            4'h5: if (n == 0 && vx == vy) pc_q <= pc_q + 12'd4;
            4'h6: v_q[x] <= nn;
            4'h7: v_q[x] <= vx + nn;
            4'h8: begin
              case (n)
                4'h0: v_q[x] <= vy;
                4'h1: v_q[x] <= vx | vy;
                4'h2: v_q[x] <= vx & vy;
                4'h3: v_q[x] <= vx ^ vy;
                4'h4: begin
                  v_q[x]  <= vx + vy;
                  v_q[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'hFF};
                end
                4'h5: begin
                  v_q[x]  <= vx - vy;
                  v_q[15] <= {7'd0, vx >= vy};
                end
                4'h6: begin
                  v_q[x]  <= vx >> 1;
                  v_q[15] <= {7'd0, vx[0]};
                end
                4'h7: begin
                  v_q[x]  <= vy - vx;
                  v_q[15] <= {7'd0, vy >= vx};
                end
                4'hE: begin
                  v_q[x]  <= vx << 1;
                  v_q[15] <= {7'd0, vx[7]};
                end
                default: ;
              endcase
            end
            4'h9: if (n == 0 && vx != vy) pc_q <= pc_q + 12'd4;
            4'hA: i_q <= {4'd0, op_q[11:0]};
            4'hB: pc_q <= op_q[11:0] + {4'd0, v_q[0]};
            4'hC: begin
              rem_q   <= {1'b0, it_q.random_value};
              state_q <= S_MOD;
            end
            4'hD: begin
              hit_q <= 1'b0;
              state_q <= (n == 0) ? S_DONE : S_SPR_MEM;
              if (n == 0) v_q[15] <= '0;
            end
            4'hE: begin
              if (nn == 8'h9E && vx < 8'd16 && lowkey[vx[3:0]]) pc_q <= pc_q + 12'd4;
              if (nn == 8'hA1 && !(vx < 8'd16 && lowkey[vx[3:0]])) pc_q <= pc_q + 12'd4;
            end
            default: begin
              case (nn)
                8'h07: v_q[x] <= dt_q;
                8'h0A: begin
                  if (lowkey == 0) begin
                    wait_q <= 1'b1;
                    pc_q   <= pc_q;
                  end else v_q[x] <= {4'd0, keyidx};
                end
                8'h15: dt_q <= vx;
                8'h18: st_q <= vx;
                8'h1E: begin
                  i_q     <= i_q + {8'd0, vx};
                  v_q[15] <= {7'd0, ({1'b0, i_q} + {9'd0, vx}) > 17'hFFF};
                end
                8'h29: i_q <= {6'd0, vx, 2'd0} + {8'd0, vx};
                8'h33: begin
                  rem_q   <= {9'd0, vx};
                  div_q   <= '0;
                  tens_q  <= '0;
                  state_q <= S_DIV;
                end
                8'h55: state_q <= S_BLOCK;
                8'h65: state_q <= S_BLOCK;
                default: ;
              endcase
            end
          endcase
        end
        S_MOD: begin
          // Restoring remainder: subtract the largest shift of (NN+1) that fits.
          if (cnt_q == 5'd16) begin
            v_q[x]  <= rem_q[7:0];
            state_q <= S_DONE;
          end else begin
            if (rem_q >= ({9'd0, nn} + 17'd1) << (5'd15 - cnt_q) &&
                (({9'd0, nn} + 17'd1) << (5'd15 - cnt_q)) >> (5'd15 - cnt_q) ==
                ({9'd0, nn} + 17'd1))
              rem_q <= rem_q - (({9'd0, nn} + 17'd1) << (5'd15 - cnt_q));
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_DIV: begin
          if (rem_q[7:0] >= 8'd100) begin
            rem_q[7:0] <= rem_q[7:0] - 8'd100;
            div_q      <= div_q + 8'd1;
          end else if (rem_q[7:0] >= 8'd10) begin
            rem_q[7:0] <= rem_q[7:0] - 8'd10;
            tens_q     <= tens_q + 4'd1;
          end else state_q <= S_BCD;
        end
        S_BCD: begin
          if (cnt_q == 5'd2) state_q <= S_DONE;
          else cnt_q <= cnt_q + 5'd1;
        end
        S_BLOCK: begin
          // The registered read returns the data of the previous address here.
          if (pend_q && nn == 8'h65) v_q[cnt_q[3:0] - 4'd1] <= mem_rdata_i;
          pend_q <= (cnt_q <= {1'b0, x});
          if (cnt_q > {1'b0, x}) begin
            state_q <= S_DONE;
            pend_q  <= 1'b0;
          end
          cnt_q <= cnt_q + 5'd1;
        end
        S_SPR_MEM: state_q <= S_SPR_FB;
        S_SPR_FB: begin
          bits_q  <= mem_rdata_i;
          state_q <= S_SPR_WR;
        end
        S_SPR_WR: begin
          // The row read in the previous state is on fb_rdata_i.
          state_q <= S_SPR_WR;
          if ((fb_rdata_i & mask) != 0) hit_q <= 1'b1;
          if (bits_q != 0) chg_q <= 1'b1;
          if (cnt_q == 5'(n) - 5'd1) begin
            v_q[15] <= {7'd0, hit_q | ((fb_rdata_i & mask) != 0)};
            state_q <= S_DONE;
            row_q   <= '0;
          end else begin
            cnt_q   <= cnt_q + 5'd1;
            state_q <= S_SPR_MEM;
          end
        end
        S_DONE: begin
          res_o.pc              <= pc_q;
          res_o.opcode          <= op_q;
          res_o.waiting_key     <= wait_q;
          res_o.display_changed <= chg_q;
          res_o.flag_value      <= v_q[15];
          res_o.sound_on        <= (st_q != 0);
          res_o.row_pixels      <= row_q;
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// Executes one command per input beat and returns one result beat.
// ----------------------------------------------------------------------------
// Usage: send a beat on s_axis (command, keys, random value, address, data).
// One beat is in work at a time. A timer tick or memory load goes straight
// to the result state and a row read through a framebuffer read state; an
// instruction fetches two opcode bytes and decodes. A sprite adds a memory
// read, framebuffer read and write per row, random a remainder loop, BCD
// store a divide by subtraction and three writes, block moves one step per
// register. A new beat is taken as the result appears if the receiver takes it.
// Every beat gives one result on m_axis from a result register; a stalled
// receiver holds the result, and the core takes a new beat only when that
// register is free or being emptied in the same cycle.
// After reset a sweep writes the font into main memory;
// s_axis_tready stays low during it. The framebuffer and registers clear
// at once.
// ----------------------------------------------------------------------------
module chip8_instruction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command, key_state, random_value, address, data
  input  logic [c8_pkg::InDataW-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pc, opcode, waiting_key, display_changed, flag_value, sound_on, row_pixels
  output logic [c8_pkg::OutDataW-1:0] m_axis_tdata
);
  import c8_pkg::*;

  logic      init_done, busy, done, fb_clear, fb_any, start;
  in_item_t  item;
  out_item_t res;
  mem_req_t  mreq;
  fb_req_t   freq;
  logic [7:0]  mrd;
  logic [63:0] frd;
  logic        ovld_q;
  out_item_t   odat_q;

  assign item  = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
  assign s_axis_tready = init_done && !busy && (!ovld_q || m_axis_tready);
  assign start = s_axis_tvalid && s_axis_tready;

  c8_mem u_mem (.clk_i, .rst_ni, .req_i(mreq), .rdata_o(mrd), .init_done_o(init_done));
  c8_fb  u_fb  (.clk_i, .rst_ni, .req_i(freq), .clear_i(fb_clear), .rdata_o(frd),
                .any_set_o(fb_any));
  c8_seq u_seq (.clk_i, .rst_ni, .start_i(start), .item_i(item), .busy_o(busy),
                .done_o(done), .res_o(res), .mem_o(mreq), .mem_rdata_i(mrd),
                .fb_o(freq), .fb_clear_o(fb_clear), .fb_rdata_i(frd),
                .fb_any_i(fb_any));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      if (done) ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
    end
  end

  assign odat_q        = res;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {1'b0, odat_q};

endmodule

// File: hw/rtl/chip8_instruction_core_checker.sv
// ----------------------------------------------------------------------------
// Instruction core port checker
// Watches the top-level ports and checks the one-in, one-out ordering.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_defines.svh"

module chip8_instruction_core_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);
  `C8_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `C8_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `C8_ASSERT_IMP(a_stall_blocks, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind chip8_instruction_core chip8_instruction_core_checker u_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready);

// File: dv/tb_chip8_instruction_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Instruction core testbench
// Sends command beats (memory loads, instruction execution, timer ticks and
// framebuffer row reads) and checks every result beat against a cycle-free
// software copy of the core's state, with random source and sink stalls.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core;
  import c8_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  chip8_instruction_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Software copy of the core state.
  logic [7:0]  mem_image [MemBytes];
  logic [7:0]  vreg [16];
  logic [15:0] index_reg;
  logic [11:0] prog_ctr;
  logic [11:0] call_stack [StackDepth];
  int unsigned call_depth;
  logic [7:0]  delay_tmr;
  logic [7:0]  sound_tmr;
  logic [63:0] screen [ScreenHeight];

  out_item_t   pending_results [$];
  int unsigned error_count;
  int unsigned burst_left;
  int unsigned idle_cycles;
  bit          hold_request;
  int unsigned hold_left;
  bit          sink_free_run;
  int unsigned sink_phase;

  function automatic logic [7:0] glyph_byte(int unsigned idx);
    logic [7:0] glyphs [80];
    glyphs = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
               8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
               8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
               8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
               8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
               8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
               8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
               8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    return glyphs[idx];
  endfunction

  task automatic clear_model();
    for (int i = 0; i < MemBytes; i++) mem_image[i] = (i < 80) ? glyph_byte(i) : 8'h00;
    for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
    for (int i = 0; i < ScreenHeight; i++) screen[i] = '0;
    index_reg  = '0;
    prog_ctr   = ProgramStart;
    call_depth = 0;
    delay_tmr  = '0;
    sound_tmr  = '0;
  endtask

  task automatic run_instruction(input in_item_t it, output out_item_t res);
    logic [15:0] op;
    logic [11:0] nnn, next;
    logic [7:0]  nn, vx, vy, bits;
    logic [3:0]  n, x, y;
    logic [8:0]  sum;
    logic        flag, hit;
    logic [4:0]  row;
    logic [5:0]  col;
    int unsigned k;
    res  = '0;
    op   = {mem_image[prog_ctr], mem_image[prog_ctr + 12'd1]};
    nnn  = op[11:0];
    nn   = op[7:0];
    n    = op[3:0];
    x    = op[11:8];
    y    = op[7:4];
    vx   = vreg[x];
    vy   = vreg[y];
    next = prog_ctr + 12'd2;
    res.opcode = op;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (int i = 0; i < ScreenHeight; i++) begin
            if (screen[i] != '0) res.display_changed = 1'b1;
            screen[i] = '0;
          end
        end else if (op == 16'h00EE && call_depth > 0) begin
          call_depth--;
          next = call_stack[call_depth] + 12'd2;
        end
      end
      4'h1: next = nnn;
      4'h2: begin
        if (call_depth < StackDepth) begin
          call_stack[call_depth] = prog_ctr;
          call_depth++;
        end
        next = nnn;
      end
      4'h3: if (vx == nn) next += 12'd2;
      4'h4: if (vx != nn) next += 12'd2;
      4'h5: if (n == 4'h0 && vx == vy) next += 12'd2;
      4'h6: vreg[x] = nn;
      4'h7: vreg[x] = vx + nn;
      4'h8: begin
        case (n)
          4'h0: vreg[x] = vy;
          4'h1: vreg[x] = vx | vy;
          4'h2: vreg[x] = vx & vy;
          4'h3: vreg[x] = vx ^ vy;
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vreg[x] = sum[7:0];
            vreg[15] = {7'd0, sum[8]};
          end
          4'h5: begin
            flag = vx >= vy;
            vreg[x] = vx - vy;
            vreg[15] = {7'd0, flag};
          end
          4'h6: begin
            vreg[x] = vx >> 1;
            vreg[15] = {7'd0, vx[0]};
          end
          4'h7: begin
            flag = vy >= vx;
            vreg[x] = vy - vx;
            vreg[15] = {7'd0, flag};
          end
          4'hE: begin
            vreg[x] = vx << 1;
            vreg[15] = {7'd0, vx[7]};
          end
          default: ;
        endcase
      end
      4'h9: if (n == 4'h0 && vx != vy) next += 12'd2;
      4'hA: index_reg = {4'h0, nnn};
      4'hB: next = nnn + {4'h0, vreg[0]};
      4'hC: vreg[x] = 8'(32'(it.random_value) % (32'(nn) + 1));
      4'hD: begin
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          bits = mem_image[12'(index_reg + 16'(r))];
          row  = 5'(vy + 8'(r));
          for (int c = 0; c < 8; c++) begin
            col = 6'(vx + 8'(c));
            if (bits[7-c]) begin
              if (screen[row][col]) hit = 1'b1;
              screen[row][col] = ~screen[row][col];
              res.display_changed = 1'b1;
            end
          end
        end
        vreg[15] = {7'd0, hit};
      end
      4'hE: begin
        flag = (vx < 8'd16) && it.key_state[vx[3:0]];
        if (nn == 8'h9E && flag) next += 12'd2;
        else if (nn == 8'hA1 && !flag) next += 12'd2;
      end
      default: begin
        case (nn)
          8'h07: vreg[x] = delay_tmr;
          8'h0A: begin
            if (it.key_state == '0) begin
              res.waiting_key = 1'b1;
              next = prog_ctr;
            end else begin
              k = 0;
              while (!it.key_state[k]) k++;
              vreg[x] = 8'(k);
            end
          end
          8'h15: delay_tmr = vx;
          8'h18: sound_tmr = vx;
          8'h1E: begin
            flag = (32'(index_reg) + 32'(vx)) > 32'hFFF;
            index_reg = index_reg + 16'(vx);
            vreg[15] = {7'd0, flag};
          end
          8'h29: index_reg = 16'(vx) * 16'd5;
          8'h33: begin
            mem_image[12'(index_reg)]          = vx / 8'd100;
            mem_image[12'(index_reg + 16'd1)] = (vx / 8'd10) % 8'd10;
            mem_image[12'(index_reg + 16'd2)] = vx % 8'd10;
          end
          8'h55: for (int i = 0; i <= x; i++) mem_image[12'(index_reg + 16'(i))] = vreg[i];
          8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem_image[12'(index_reg + 16'(i))];
          default: ;
        endcase
      end
    endcase
    prog_ctr = next;
  endtask

  task automatic predict_result(input in_item_t it, output out_item_t res);
    res = '0;
    case (it.command)
      CmdExec: run_instruction(it, res);
      CmdTick: begin
        if (delay_tmr != 0) delay_tmr--;
        if (sound_tmr != 0) sound_tmr--;
      end
      CmdLoad: mem_image[it.address] = it.data;
      default: res.row_pixels = screen[it.address[4:0]];
    endcase
    res.pc         = prog_ctr;
    res.flag_value = vreg[15];
    res.sound_on   = sound_tmr != 0;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] keys,
                           input logic [15:0] rnd, input logic [11:0] addr,
                           input logic [7:0] dat);
    in_item_t  it;
    out_item_t res;
    it = '{data: dat, address: addr, random_value: rnd, key_state: keys, command: cmd};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'd0, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_result(it, res);
    pending_results.push_back(res);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic exec_word(input logic [15:0] op, input logic [15:0] keys = 16'h0001,
                           input logic [15:0] rnd = '0);
    send_item(CmdLoad, 16'($urandom), 16'($urandom), prog_ctr, op[15:8]);
    send_item(CmdLoad, 16'($urandom), 16'($urandom), prog_ctr + 12'd1, op[7:0]);
    send_item(CmdExec, keys, rnd, 12'($urandom), 8'($urandom));
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = out_item_t'(m_axis_tdata[102:0]);
      if (pending_results.size() == 0) begin
        $display("result beat with no expected result");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.pc != want.pc) report_mismatch("pc", 64'(got.pc), 64'(want.pc));
        if (got.opcode != want.opcode)
          report_mismatch("opcode", 64'(got.opcode), 64'(want.opcode));
        if (got.waiting_key != want.waiting_key)
          report_mismatch("waiting_key", 64'(got.waiting_key), 64'(want.waiting_key));
        if (got.display_changed != want.display_changed)
          report_mismatch("display_changed", 64'(got.display_changed),
                          64'(want.display_changed));
        if (got.flag_value != want.flag_value)
          report_mismatch("flag_value", 64'(got.flag_value), 64'(want.flag_value));
        if (got.sound_on != want.sound_on)
          report_mismatch("sound_on", 64'(got.sound_on), 64'(want.sound_on));
        if (got.row_pixels != want.row_pixels)
          report_mismatch("row_pixels", got.row_pixels, want.row_pixels);
      end
    end
  end

  always @(posedge clk_i) begin
    sink_phase++;
    if (sink_phase % 300 == 0) sink_free_run = $urandom_range(0, 2) == 0;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_free_run || ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_item(CmdRead, 16'($urandom), 16'($urandom), 12'd0, 8'($urandom));
    send_item(CmdExec, 16'h0000, 16'h0000, 12'd0, 8'd0);
    send_item(CmdTick, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF);
  endtask

  task automatic test_directed_ops();
    logic [15:0] ops [] = '{16'h60FF, 16'h6101, 16'h8F14, 16'h6F05, 16'h8FF5,
                            16'h820E, 16'h8126, 16'h8017, 16'hC07F, 16'hF018,
                            16'hF015, 16'h00E0, 16'hA000, 16'hD01F, 16'hD01F,
                            16'hF11E, 16'hF033, 16'h2300, 16'h00EE, 16'h00EE};
    foreach (ops[i]) exec_word(ops[i], 16'($urandom), 16'($urandom));
    exec_word(16'hF30A, 16'h0000);
    exec_word(16'hF30A, 16'h8000);
    exec_word(16'hE39E, 16'h8000);
    send_item(CmdTick, 16'h0, 16'h0, 12'h0, 8'h0);
    send_item(CmdLoad, 16'h0, 16'h0, 12'hFFF, 8'hFF);
    send_item(CmdRead, 16'h0, 16'h0, 12'hFFF, 8'h0);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [3:0] sel, x, y;
    logic [7:0] nn;
    logic [7:0] fsel [] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55,
                            8'h65, 8'h00};
    sel = 4'($urandom);
    x   = 4'($urandom);
    y   = 4'($urandom);
    nn  = 8'($urandom);
    case (sel)
      4'h0: return ($urandom_range(0, 2) == 0) ? 16'h00E0 :
                   ($urandom_range(0, 3) != 0) ? 16'h00EE : {4'h0, x, nn};
      4'h8: return {4'h8, x, y, 4'($urandom_range(0, 15))};
      4'hE: return {4'hE, x, ($urandom_range(0, 2) == 0) ? 8'h9E :
                   ($urandom_range(0, 1) == 0) ? 8'hA1 : nn};
      4'hF: return {4'hF, x, fsel[$urandom_range(0, 9)]};
      default: return {sel, x, nn};
    endcase
  endfunction

  task automatic test_random_program(input int unsigned rounds);
    logic [15:0] keys;
    for (int unsigned i = 0; i < rounds; i++) begin
      keys = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom);
      case ($urandom_range(0, 9))
        0: send_item(CmdTick, 16'($urandom), 16'($urandom), 12'($urandom), 8'($urandom));
        1: send_item(CmdRead, 16'($urandom), 16'($urandom), 12'($urandom), 8'($urandom));
        2: send_item(CmdLoad, 16'($urandom), 16'($urandom), 12'($urandom), 8'($urandom));
        3: send_item(CmdExec, keys, 16'($urandom), 12'($urandom), 8'($urandom));
        default: exec_word(random_opcode(), keys, 16'($urandom));
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    burst_left = 40;
    test_random_program(20);
  endtask

  initial begin
    error_count   = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    sink_free_run = 1'b0;
    sink_phase    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    clear_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_ops();
    test_backpressure();
    test_random_program(170);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/c8_pkg.sv
hw/rtl/c8_mem.sv
hw/rtl/c8_fb.sv
hw/rtl/c8_seq.sv
hw/rtl/chip8_instruction_core.sv
hw/rtl/chip8_instruction_core_checker.sv
dv/tb_chip8_instruction_core.sv
